// ===== src/seg_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_pkg
// Shared constants and controller/datapath interface types for the signed
// Elias gamma encoder.
// ----------------------------------------------------------------------------
package seg_pkg;

    // Default width of the signed input value
    localparam int SEG_VALUE_BITS = 16;
    // Output byte width
    localparam int SEG_BYTE_W     = 8;
    // Leftover bits kept between items, and their count width
    localparam int SEG_PEND_W     = 7;
    localparam int SEG_CNT_W      = 3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture and map the accepted item
        logic size;    // measure the code length
        logic align;   // build the left-aligned bit string
        logic shift;   // drop the byte just delivered
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic has_bytes;   // at least one byte waits
        logic last_byte;   // exactly one byte waits
    } t_dp_status;

endpackage

// ===== src/seg_ctrl.sv =====
// ----------------------------------------------------------------------------
// seg_ctrl
// Sequencer for the encoder: accepts an item, steps the datapath through
// sizing and alignment, then hands out the packed bytes one per handshake.
// ----------------------------------------------------------------------------
module seg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output seg_pkg::t_dp_cmd   o_cmd,
    input  seg_pkg::t_dp_status i_status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SIZE  = 4'b0010,
        ST_ALIGN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Handshake outputs
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT) && i_status.has_bytes;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SIZE;
                end
            end
            ST_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = ST_ALIGN;
            end
            ST_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.has_bytes) begin
                    n_state = ST_IDLE;
                end else if (i_out_ready) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Never take a new item while a byte is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while output valid");

    // A stalled byte keeps the sequencer in the emit state
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (r_state == ST_EMIT))
        else $error("emit state left during output stall");

    // An accepted item always goes to sizing next
    a_accept_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SIZE))
        else $error("accepted item did not start sizing");

endmodule

// ===== src/seg_datapath.sv =====
// ----------------------------------------------------------------------------
// seg_datapath
// Maps the signed value to its positive code, measures the gamma code, merges
// it behind the leftover bits and shifts out whole bytes; flush pads them.
// ----------------------------------------------------------------------------
module seg_datapath #(
    parameter int VALUE_BITS = seg_pkg::SEG_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic                          i_flush,
    input  seg_pkg::t_dp_cmd              i_cmd,
    output seg_pkg::t_dp_status           o_status,
    output logic [seg_pkg::SEG_BYTE_W-1:0] o_byte
);

    localparam int MW     = VALUE_BITS + 1;                 // mapped code width
    localparam int BW_W   = $clog2(MW + 1);                 // bit width of m
    localparam int LEN_W  = $clog2(2 * MW);                 // gamma length
    localparam int SR_W   = 2 * VALUE_BITS + 8;             // pending + code
    localparam int T_W    = $clog2(SR_W + 1);
    localparam int MAX_NB = SR_W / 8;
    localparam int NB_W   = $clog2(MAX_NB + 1);
    localparam int PW     = seg_pkg::SEG_PEND_W;
    localparam int CW     = seg_pkg::SEG_CNT_W;
    localparam int BYW    = seg_pkg::SEG_BYTE_W;

    logic [MW-1:0]    r_m;
    logic             r_flush;
    logic [LEN_W-1:0] r_len;
    logic [T_W-1:0]   r_total;
    logic [SR_W-1:0]  r_sr;
    logic [NB_W-1:0]  r_nb;
    logic [PW-1:0]    r_pend_bits;
    logic [CW-1:0]    r_pend_cnt;

    logic [MW-1:0]    n_m;
    logic [BW_W-1:0]  n_bw;
    logic [LEN_W-1:0] n_len;
    logic [T_W-1:0]   n_total;
    logic [SR_W-1:0]  n_sr;
    logic [NB_W-1:0]  n_nb;
    logic [PW-1:0]    n_pend_bits;
    logic [CW-1:0]    n_pend_cnt;
    logic [PW-1:0]    n_low;
    logic [CW-1:0]    n_rem;
    logic [14:0]      n_flush_wide;

    // Map signed value: negative x -> -2x, otherwise 2x+1
    always_comb begin
        if (i_value[VALUE_BITS-1]) begin
            n_m = {VALUE_BITS'(-i_value), 1'b0};
        end else begin
            n_m = {i_value, 1'b1};
        end
    end

    // Bit width of m by priority search, code length 2*bw-1
    always_comb begin
        n_bw = '0;
        for (int i = 0; i < MW; i++) begin
            if (r_m[i]) begin
                n_bw = BW_W'(i + 1);
            end
        end
        n_len   = LEN_W'({n_bw, 1'b0}) - LEN_W'(1);
        n_total = T_W'(r_pend_cnt) + T_W'(n_len);
    end

    // Left-align pending bits and code, split into bytes and leftover
    always_comb begin
        n_rem        = r_total[CW-1:0];
        n_low        = (r_pend_bits << r_len) | PW'(r_m);
        n_flush_wide = 15'(r_pend_bits) << (4'd8 - 4'(r_pend_cnt));
        if (r_flush) begin
            n_sr        = {n_flush_wide[BYW-1:0], (SR_W-BYW)'(0)};
            n_nb        = NB_W'(r_pend_cnt != '0);
            n_pend_bits = '0;
            n_pend_cnt  = '0;
        end else begin
            n_sr        = (SR_W'(r_pend_bits) << (T_W'(SR_W) - T_W'(r_pend_cnt)))
                        | (SR_W'(r_m) << (T_W'(SR_W) - r_total));
            n_nb        = NB_W'(r_total >> 3);
            n_pend_bits = n_low & ((PW'(1) << n_rem) - PW'(1));
            n_pend_cnt  = n_rem;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m     <= n_m;
            r_flush <= i_flush;
        end
        if (i_cmd.size) begin
            r_len   <= n_len;
            r_total <= n_total;
        end
        if (i_cmd.align) begin
            r_sr <= n_sr;
        end else if (i_cmd.shift) begin
            r_sr <= r_sr << BYW;
        end
    end

    // Leftover bits and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_nb        <= '0;
        end else begin
            if (i_cmd.align) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_nb        <= n_nb;
            end else if (i_cmd.shift) begin
                r_nb <= r_nb - NB_W'(1);
            end
        end
    end

    assign o_byte             = r_sr[SR_W-1 -: BYW];
    assign o_status.has_bytes = (r_nb != '0);
    assign o_status.last_byte = (r_nb == NB_W'(1));

    // Leftover bits above the count stay clear
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits >> r_pend_cnt) == '0)
        else $error("stale bits above pending count");

    // Each delivered byte lowers the count by one
    a_nb_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |=> (r_nb == $past(r_nb) - NB_W'(1)))
        else $error("byte count did not step");

    // No delivery with no byte waiting
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_nb != '0))
        else $error("shift with no byte waiting");

endmodule

// ===== src/signed_elias_gamma_encoder.sv =====
// ----------------------------------------------------------------------------
// signed_elias_gamma_encoder
// Signed Elias gamma encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// Sequence: an accepted item passes through the size and align states, then
//   its bytes are offered in the emit state, which it enters even with none.
// Throughput: an item produces 0..5 bytes at 16 bits; a new item is taken
//   only back in idle, after its last byte; bytes leave one per cycle while
//   i_m_axis_tready is high, from a single shift register.
// Reset: synchronous active-low; clears the sequencer, byte count and the
//   up to 7 leftover code bits.
module signed_elias_gamma_encoder #(
    parameter int VALUE_BITS = seg_pkg::SEG_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [VALUE_BITS-1:0] value, zero padded to whole bytes
    input  logic [((VALUE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // [0] flush
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] out_byte
    output logic [seg_pkg::SEG_BYTE_W-1:0] o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    seg_pkg::t_dp_cmd    w_cmd;
    seg_pkg::t_dp_status w_status;

    // Sequencer
    seg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Code build and byte shifter
    seg_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_flush  (i_s_axis_tuser),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_byte   (o_m_axis_tdata)
    );

    assign o_m_axis_tlast = w_status.last_byte;

endmodule
